>>> src/mtep_pkg.sv
// Package with the types, codes and helpers of the MIDI track event parser.
`default_nettype none

package mtep_pkg;

    // Parser phase while walking one track body
    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA1  = 4'd2,
        PH_DATA2  = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_MBODY  = 4'd6,
        PH_XLEN   = 4'd7,
        PH_XBODY  = 4'd8,
        PH_DONE   = 4'd9,
        PH_ERROR  = 4'd10
    } t_phase;

    // Kinds of result item
    localparam logic [1:0] KIND_CHAN  = 2'd0;
    localparam logic [1:0] KIND_TEMPO = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // Byte codes of the file format
    localparam logic [7:0] DATA_MASK    = 8'h7F;
    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_ESC   = 8'hF7;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [3:0] NIB_PROG     = 4'hC;
    localparam logic [3:0] NIB_CHPRESS  = 4'hD;
    localparam logic [3:0] NIB_PITCH    = 4'hE;

    localparam int unsigned LEN_W   = 28;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned TEMPO_W = 24;

    localparam logic [2:0]        VLQ_MAX_BYTES = 3'd4;
    localparam logic [LEN_W-1:0]  TEMPO_LEN     = 28'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TICK_W-1:0]  event_tick;
        logic [7:0]         status_byte;
        logic [7:0]         first_data;
        logic [7:0]         second_data;
        logic [TEMPO_W-1:0] tempo_value;
        logic               last_of_run;
    } t_result;

    // Number of data bytes of a channel message, zero for anything else
    function automatic logic [1:0] msg_len(input logic [7:0] st);
        logic [3:0] hi;
        hi = st[7:4];
        if (hi == NIB_PROG || hi == NIB_CHPRESS) begin
            msg_len = 2'd1;
        end else if (hi inside {[4'h8:4'hB], NIB_PITCH}) begin
            msg_len = 2'd2;
        end else begin
            msg_len = 2'd0;
        end
    endfunction

    function automatic t_result mk_result(input logic [1:0]         kind,
                                          input logic [TICK_W-1:0]  tick,
                                          input logic [7:0]         st,
                                          input logic [7:0]         d1,
                                          input logic [7:0]         d2,
                                          input logic [TEMPO_W-1:0] tempo);
        t_result r;
        r.kind        = kind;
        r.event_tick  = tick;
        r.status_byte = st;
        r.first_data  = d1;
        r.second_data = d2;
        r.tempo_value = tempo;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/mtep_if.sv
// Handshake interfaces for the byte stream and the result stream.
`default_nettype none

interface mtep_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       track_start;

    modport source (output valid, output data_byte, output last_byte,
                    output track_start, input ready);
    modport sink   (input valid, input data_byte, input last_byte,
                    input track_start, output ready);
endinterface

interface mtep_event_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic [mtep_pkg::TICK_W-1:0]   event_tick;
    logic [7:0]                    status_byte;
    logic [7:0]                    first_data;
    logic [7:0]                    second_data;
    logic [mtep_pkg::TEMPO_W-1:0]  tempo_value;
    logic                          last_of_run;

    modport source (output valid, output kind, output event_tick,
                    output status_byte, output first_data, output second_data,
                    output tempo_value, output last_of_run, input ready);
    modport sink   (input valid, input kind, input event_tick,
                    input status_byte, input first_data, input second_data,
                    input tempo_value, input last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/midi_track_event_parser_core.sv
// Top level of the MIDI track event parser: byte decoder and result queue.
//
//  Channel  Direction  Carries
//  -------  ---------  -------------------------------------------------------
//  i_byte   in         one track body byte per item, last_byte, track_start
//  o_evt    out        one result per item: kind, tick, message, tempo, flag
//
//  Each accepted byte is decoded in the cycle it is taken; its results (none,
//  one or two) are written into a small result queue at the same clock edge.
//  A byte may therefore be accepted in every cycle. The input is held off
//  only while the queue lacks room for two results, so the sustained rate is
//  one byte per cycle whenever the sink drains results as they appear.
//  i_rst_n is synchronous and active low; it empties the queue and returns
//  the parser to reading the first delta time of a track.
`default_nettype none

module midi_track_event_parser_core #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    mtep_byte_if.sink     i_byte,
    mtep_event_if.source  o_evt
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ROOM = CNT_W'(FIFO_DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    // Parser state
    mtep_pkg::t_phase                r_phase,   n_phase;
    logic [7:0]                      r_running, n_running;
    logic [mtep_pkg::TICK_W-1:0]     r_tick,    n_tick;
    logic [mtep_pkg::LEN_W-1:0]      r_acc,     n_acc;
    logic [2:0]                      r_cnt,     n_cnt;
    logic [7:0]                      r_cur,     n_cur;
    logic [7:0]                      r_held,    n_held;
    logic [7:0]                      r_meta,    n_meta;
    logic [mtep_pkg::LEN_W-1:0]      r_skip,    n_skip;
    logic [mtep_pkg::TEMPO_W-1:0]    r_tempo,   n_tempo;

    // Result queue
    mtep_pkg::t_result               r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]                r_wptr, r_rptr;
    logic [CNT_W-1:0]                r_count;

    logic                            accept, pop;
    logic [7:0]                      b;
    logic                            last;
    logic                            ev_valid, end_valid;
    mtep_pkg::t_result               ev;
    mtep_pkg::t_result               res0, res1;
    logic [1:0]                      nres;
    logic [mtep_pkg::LEN_W-1:0]      vlq_acc;
    logic [2:0]                      vlq_cnt;
    logic                            vlq_done, vlq_long;
    logic [mtep_pkg::LEN_W-1:0]      skip_dec;
    logic [PTR_W-1:0]                wptr_inc, wptr_inc2, rptr_inc;

    assign accept = i_byte.valid && i_byte.ready;
    assign pop    = o_evt.valid && o_evt.ready;
    assign b      = i_byte.data_byte;
    assign last   = i_byte.last_byte;

    // Ready comes from the registered fill level, so the queue always has
    // room for the two results that one byte can cause.
    assign i_byte.ready = (r_count <= CNT_ROOM);

    // Decoder: starts from the current state, or from the reset state when
    // the byte opens a new track, and works out the next state and results.
    always_comb begin
        if (i_byte.track_start) begin
            n_phase   = mtep_pkg::PH_DELTA;
            n_running = '0;
            n_tick    = '0;
            n_acc     = '0;
            n_cnt     = '0;
            n_cur     = '0;
            n_held    = '0;
            n_meta    = '0;
            n_skip    = '0;
            n_tempo   = '0;
        end else begin
            n_phase   = r_phase;
            n_running = r_running;
            n_tick    = r_tick;
            n_acc     = r_acc;
            n_cnt     = r_cnt;
            n_cur     = r_cur;
            n_held    = r_held;
            n_meta    = r_meta;
            n_skip    = r_skip;
            n_tempo   = r_tempo;
        end

        // Variable-length quantity step on the length or delta being decoded
        vlq_acc  = {n_acc[mtep_pkg::LEN_W-8:0], b[6:0]};
        vlq_cnt  = n_cnt + 3'd1;
        vlq_done = !b[7];
        vlq_long = b[7] && (vlq_cnt >= mtep_pkg::VLQ_MAX_BYTES);
        skip_dec = n_skip - mtep_pkg::LEN_W'(1);

        ev_valid  = 1'b0;
        end_valid = 1'b0;
        ev = mtep_pkg::mk_result(mtep_pkg::KIND_ERR, n_tick, 8'd0, 8'd0, 8'd0, '0);

        case (n_phase)
            mtep_pkg::PH_DELTA: begin
                n_acc = vlq_acc;
                n_cnt = vlq_cnt;
                if (vlq_long || (!vlq_done && last)) begin
                    n_phase  = mtep_pkg::PH_ERROR;
                    ev_valid = 1'b1;
                end else if (vlq_done) begin
                    n_tick = n_tick + {4'd0, vlq_acc};
                    n_acc  = '0;
                    n_cnt  = '0;
                    if (last) begin
                        n_phase   = mtep_pkg::PH_DONE;
                        end_valid = 1'b1;
                    end else begin
                        n_phase = mtep_pkg::PH_STATUS;
                    end
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    // Data byte under running status
                    if (n_running == 8'd0) begin
                        n_phase  = mtep_pkg::PH_ERROR;
                        ev_valid = 1'b1;
                    end else begin
                        n_cur = n_running;
                        if (mtep_pkg::msg_len(n_running) == 2'd1) begin
                            ev_valid = 1'b1;
                            ev = mtep_pkg::mk_result(mtep_pkg::KIND_CHAN, n_tick,
                                                     n_running, b, 8'd0, '0);
                            n_acc = '0;
                            n_cnt = '0;
                            if (last) begin
                                n_phase   = mtep_pkg::PH_DONE;
                                end_valid = 1'b1;
                            end else begin
                                n_phase = mtep_pkg::PH_DELTA;
                            end
                        end else if (last) begin
                            n_phase  = mtep_pkg::PH_ERROR;
                            ev_valid = 1'b1;
                        end else begin
                            n_held  = b;
                            n_phase = mtep_pkg::PH_DATA2;
                        end
                    end
                end else begin
                    n_cur = b;
                    if (last) begin
                        n_phase  = mtep_pkg::PH_ERROR;
                        ev_valid = 1'b1;
                    end else if (b == mtep_pkg::STATUS_META) begin
                        n_running = '0;
                        n_phase   = mtep_pkg::PH_MTYPE;
                    end else if (b == mtep_pkg::STATUS_SYSEX ||
                                 b == mtep_pkg::STATUS_ESC) begin
                        n_running = '0;
                        n_acc     = '0;
                        n_cnt     = '0;
                        n_phase   = mtep_pkg::PH_XLEN;
                    end else if (mtep_pkg::msg_len(b) == 2'd0) begin
                        n_phase  = mtep_pkg::PH_ERROR;
                        ev_valid = 1'b1;
                    end else begin
                        n_running = b;
                        n_phase   = mtep_pkg::PH_DATA1;
                    end
                end
            end
            mtep_pkg::PH_DATA1: begin
                n_held = b;
                if (mtep_pkg::msg_len(n_cur) == 2'd1) begin
                    ev_valid = 1'b1;
                    ev = mtep_pkg::mk_result(mtep_pkg::KIND_CHAN, n_tick,
                                             n_cur, b, 8'd0, '0);
                    n_acc = '0;
                    n_cnt = '0;
                    if (last) begin
                        n_phase   = mtep_pkg::PH_DONE;
                        end_valid = 1'b1;
                    end else begin
                        n_phase = mtep_pkg::PH_DELTA;
                    end
                end else if (last) begin
                    n_phase  = mtep_pkg::PH_ERROR;
                    ev_valid = 1'b1;
                end else begin
                    n_phase = mtep_pkg::PH_DATA2;
                end
            end
            mtep_pkg::PH_DATA2: begin
                ev_valid = 1'b1;
                ev = mtep_pkg::mk_result(mtep_pkg::KIND_CHAN, n_tick,
                                         n_cur, n_held, b, '0);
                n_acc = '0;
                n_cnt = '0;
                if (last) begin
                    n_phase   = mtep_pkg::PH_DONE;
                    end_valid = 1'b1;
                end else begin
                    n_phase = mtep_pkg::PH_DELTA;
                end
            end
            mtep_pkg::PH_MTYPE: begin
                n_meta = b;
                n_acc  = '0;
                n_cnt  = '0;
                if (last) begin
                    n_phase  = mtep_pkg::PH_ERROR;
                    ev_valid = 1'b1;
                end else begin
                    n_phase = mtep_pkg::PH_MLEN;
                end
            end
            mtep_pkg::PH_MLEN, mtep_pkg::PH_XLEN: begin
                n_acc = vlq_acc;
                n_cnt = vlq_cnt;
                if (vlq_long || (!vlq_done && last)) begin
                    n_phase  = mtep_pkg::PH_ERROR;
                    ev_valid = 1'b1;
                end else if (vlq_done) begin
                    if (vlq_acc == '0) begin
                        // Empty body: the event is over at once
                        n_acc = '0;
                        n_cnt = '0;
                        if (last) begin
                            n_phase   = mtep_pkg::PH_DONE;
                            end_valid = 1'b1;
                        end else begin
                            n_phase = mtep_pkg::PH_DELTA;
                        end
                    end else if (last) begin
                        n_phase  = mtep_pkg::PH_ERROR;
                        ev_valid = 1'b1;
                    end else begin
                        n_skip  = vlq_acc;
                        n_tempo = '0;
                        n_phase = (n_phase == mtep_pkg::PH_MLEN) ?
                                  mtep_pkg::PH_MBODY : mtep_pkg::PH_XBODY;
                    end
                end
            end
            mtep_pkg::PH_MBODY, mtep_pkg::PH_XBODY: begin
                n_tempo = {n_tempo[mtep_pkg::TEMPO_W-9:0], b};
                n_skip  = skip_dec;
                if (skip_dec == '0) begin
                    // The body length is still held in the accumulator here
                    if (n_phase == mtep_pkg::PH_MBODY &&
                        n_meta == mtep_pkg::META_TEMPO &&
                        n_acc == mtep_pkg::TEMPO_LEN) begin
                        ev_valid = 1'b1;
                        ev = mtep_pkg::mk_result(mtep_pkg::KIND_TEMPO, n_tick,
                                                 8'd0, 8'd0, 8'd0, n_tempo);
                    end
                    n_acc = '0;
                    n_cnt = '0;
                    if (last) begin
                        n_phase   = mtep_pkg::PH_DONE;
                        end_valid = 1'b1;
                    end else begin
                        n_phase = mtep_pkg::PH_DELTA;
                    end
                end else if (last) begin
                    n_phase  = mtep_pkg::PH_ERROR;
                    ev_valid = 1'b1;
                end
            end
            default: begin
                // Track finished or failed: bytes are dropped until a new start
            end
        endcase

        // Pack the results in order: the event first, then end of track
        res0 = ev_valid ? ev :
               mtep_pkg::mk_result(mtep_pkg::KIND_END, n_tick, 8'd0, 8'd0, 8'd0, '0);
        res1 = mtep_pkg::mk_result(mtep_pkg::KIND_END, n_tick, 8'd0, 8'd0, 8'd0, '0);
        res0.last_of_run = !(ev_valid && end_valid);
        res1.last_of_run = 1'b1;
        nres = {1'b0, ev_valid} + {1'b0, end_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtep_pkg::PH_DELTA;
            r_running <= '0;
            r_tick    <= '0;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_cur     <= '0;
            r_held    <= '0;
            r_meta    <= '0;
            r_skip    <= '0;
            r_tempo   <= '0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_running <= n_running;
            r_tick    <= n_tick;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_cur     <= n_cur;
            r_held    <= n_held;
            r_meta    <= n_meta;
            r_skip    <= n_skip;
            r_tempo   <= n_tempo;
        end
    end

    // Result queue: up to two writes and one read per cycle
    assign wptr_inc  = (r_wptr == PTR_LAST) ? '0 : r_wptr + PTR_W'(1);
    assign wptr_inc2 = (wptr_inc == PTR_LAST) ? '0 : wptr_inc + PTR_W'(1);
    assign rptr_inc  = (r_rptr == PTR_LAST) ? '0 : r_rptr + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (accept && nres != 2'd0) begin
            r_fifo[r_wptr] <= res0;
        end
        if (accept && nres == 2'd2) begin
            r_fifo[wptr_inc] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (accept && nres == 2'd1) begin
                r_wptr <= wptr_inc;
            end else if (accept && nres == 2'd2) begin
                r_wptr <= wptr_inc2;
            end
            if (pop) begin
                r_rptr <= rptr_inc;
            end
            r_count <= r_count + (accept ? CNT_W'(nres) : '0) - CNT_W'(pop);
        end
    end

    assign o_evt.valid       = (r_count != '0);
    assign o_evt.kind        = r_fifo[r_rptr].kind;
    assign o_evt.event_tick  = r_fifo[r_rptr].event_tick;
    assign o_evt.status_byte = r_fifo[r_rptr].status_byte;
    assign o_evt.first_data  = r_fifo[r_rptr].first_data;
    assign o_evt.second_data = r_fifo[r_rptr].second_data;
    assign o_evt.tempo_value = r_fifo[r_rptr].tempo_value;
    assign o_evt.last_of_run = r_fifo[r_rptr].last_of_run;

`ifndef NO_ASSERTIONS
    // The queue never holds more than its depth
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("result queue overflow");

    // A finished or failed track yields nothing until the next track start
    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_byte.track_start &&
         (r_phase == mtep_pkg::PH_DONE || r_phase == mtep_pkg::PH_ERROR))
        |-> (nres == 2'd0))
        else $error("result produced after end of track");

    // An error result always leaves the parser in the error phase
    a_error_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && nres != 2'd0 && res0.kind == mtep_pkg::KIND_ERR)
        |=> (r_phase == mtep_pkg::PH_ERROR))
        else $error("error result without error phase");

    // A result stays on the queue's output until the sink takes it
    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_evt.valid && !o_evt.ready) |=> (o_evt.valid && $stable(r_rptr)))
        else $error("result dropped while stalled");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the MIDI track event parser: stimulus, decoder model and checker.
`timescale 1ns / 1ps

module testbench;

    // Bytes and codes that only the stimulus needs
    localparam logic [7:0]                 META_EOT     = 8'h2F;
    localparam logic [3:0]                 NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0]                 NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0]                 NIB_POLY     = 4'hA;
    localparam logic [3:0]                 NIB_CTRL     = 4'hB;
    localparam logic [mtep_pkg::LEN_W-1:0] MAX_VLQ      = 28'hFFFFFFF;
    localparam logic [7:0]                 CONT_BIT     = 8'h80;

    // Ways of damaging a well-formed track
    localparam int BRK_NONE       = 0;
    localparam int BRK_TRUNCATE   = 1;
    localparam int BRK_GARBLE     = 2;
    localparam int BRK_LONG_DELTA = 3;
    localparam int BRK_LONG_LEN   = 4;

    localparam int TARGET_ITEMS = 1100;
    localparam int QUIET_TAIL   = 120;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       start;
    } t_stim;

    typedef struct packed {
        t_stim                       s;
        logic                        typed;
        logic [1:0]                  kind;
        logic [mtep_pkg::TICK_W-1:0] tick;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n;

    mtep_byte_if  byte_ch ();
    mtep_event_if evt_ch ();

    midi_track_event_parser_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch),
        .o_evt   (evt_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder model state
    mtep_pkg::t_phase             parse_state;
    logic [7:0]                   run_status;
    logic [7:0]                   cur_status;
    logic [7:0]                   first_held;
    logic [7:0]                   meta_code;
    logic [mtep_pkg::TICK_W-1:0]  abs_tick;
    logic [mtep_pkg::LEN_W-1:0]   len_acc;
    logic [mtep_pkg::LEN_W-1:0]   skip_left;
    logic [2:0]                   len_cnt;
    logic [mtep_pkg::TEMPO_W-1:0] tempo_acc;

    mtep_pkg::t_result byte_results[$];
    mtep_pkg::t_result pending_events[$];
    t_stim             track_bytes[$];
    t_dir_row          dir_rows[$];

    int  sent_bytes   = 0;
    int  event_errors = 0;
    bit  gaps_on      = 1'b0;

    function automatic int unsigned channel_data_len(input logic [7:0] st);
        case (st[7:4])
            mtep_pkg::NIB_PROG, mtep_pkg::NIB_CHPRESS: return 1;
            NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY, NIB_CTRL,
            mtep_pkg::NIB_PITCH:                       return 2;
            default:                                   return 0;
        endcase
    endfunction

    function automatic void clear_parser();
        parse_state = mtep_pkg::PH_DELTA;
        run_status  = '0;
        cur_status  = '0;
        first_held  = '0;
        meta_code   = '0;
        abs_tick    = '0;
        len_acc     = '0;
        skip_left   = '0;
        len_cnt     = '0;
        tempo_acc   = '0;
    endfunction

    function automatic void note_event(input logic [1:0] kind, input logic [7:0] st,
                                       input logic [7:0] d1, input logic [7:0] d2,
                                       input logic [mtep_pkg::TEMPO_W-1:0] tempo);
        mtep_pkg::t_result r;
        r.kind        = kind;
        r.event_tick  = abs_tick;
        r.status_byte = st;
        r.first_data  = d1;
        r.second_data = d2;
        r.tempo_value = tempo;
        r.last_of_run = 1'b0;
        byte_results.push_back(r);
    endfunction

    function automatic void parse_error();
        parse_state = mtep_pkg::PH_ERROR;
        note_event(mtep_pkg::KIND_ERR, '0, '0, '0, '0);
    endfunction

    // An event is complete: either the body ends here or another delta follows.
    function automatic void close_event(input logic lst);
        len_acc = '0;
        len_cnt = '0;
        if (lst) begin
            parse_state = mtep_pkg::PH_DONE;
            note_event(mtep_pkg::KIND_END, '0, '0, '0, '0);
        end else begin
            parse_state = mtep_pkg::PH_DELTA;
        end
    endfunction

    // One byte of a variable-length quantity: 1 complete, 0 more to come, -1 too long.
    function automatic int take_length_byte(input logic [7:0] b);
        len_acc = {len_acc[mtep_pkg::LEN_W-8:0], b[6:0]};
        len_cnt = len_cnt + 3'd1;
        if (!b[7]) return 1;
        if (len_cnt >= mtep_pkg::VLQ_MAX_BYTES) return -1;
        return 0;
    endfunction

    // Works out the results that one accepted byte causes, into byte_results.
    function automatic void decode_track_byte(input logic [7:0] b, input logic lst,
                                              input logic st);
        int r;
        byte_results.delete();
        if (st) clear_parser();
        case (parse_state)
            mtep_pkg::PH_DELTA: begin
                r = take_length_byte(b);
                if (r < 0 || (r == 0 && lst)) begin
                    parse_error();
                end else if (r == 1) begin
                    abs_tick = abs_tick + mtep_pkg::TICK_W'(len_acc);
                    len_acc  = '0;
                    len_cnt  = '0;
                    if (lst) begin
                        parse_state = mtep_pkg::PH_DONE;
                        note_event(mtep_pkg::KIND_END, '0, '0, '0, '0);
                    end else begin
                        parse_state = mtep_pkg::PH_STATUS;
                    end
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    // Data byte in status position: running status applies.
                    if (run_status == '0) begin
                        parse_error();
                    end else begin
                        cur_status = run_status;
                        if (channel_data_len(cur_status) == 1) begin
                            note_event(mtep_pkg::KIND_CHAN, cur_status, b, '0, '0);
                            close_event(lst);
                        end else if (lst) begin
                            parse_error();
                        end else begin
                            first_held  = b;
                            parse_state = mtep_pkg::PH_DATA2;
                        end
                    end
                end else begin
                    cur_status = b;
                    if (lst) begin
                        parse_error();
                    end else if (b == mtep_pkg::STATUS_META) begin
                        run_status  = '0;
                        parse_state = mtep_pkg::PH_MTYPE;
                    end else if (b == mtep_pkg::STATUS_SYSEX ||
                                 b == mtep_pkg::STATUS_ESC) begin
                        run_status  = '0;
                        len_acc     = '0;
                        len_cnt     = '0;
                        parse_state = mtep_pkg::PH_XLEN;
                    end else if (channel_data_len(b) == 0) begin
                        parse_error();
                    end else begin
                        run_status  = b;
                        parse_state = mtep_pkg::PH_DATA1;
                    end
                end
            end
            mtep_pkg::PH_DATA1: begin
                first_held = b;
                if (channel_data_len(cur_status) == 1) begin
                    note_event(mtep_pkg::KIND_CHAN, cur_status, b, '0, '0);
                    close_event(lst);
                end else if (lst) begin
                    parse_error();
                end else begin
                    parse_state = mtep_pkg::PH_DATA2;
                end
            end
            mtep_pkg::PH_DATA2: begin
                note_event(mtep_pkg::KIND_CHAN, cur_status, first_held, b, '0);
                close_event(lst);
            end
            mtep_pkg::PH_MTYPE: begin
                meta_code = b;
                len_acc   = '0;
                len_cnt   = '0;
                if (lst) parse_error();
                else     parse_state = mtep_pkg::PH_MLEN;
            end
            mtep_pkg::PH_MLEN, mtep_pkg::PH_XLEN: begin
                r = take_length_byte(b);
                if (r < 0 || (r == 0 && lst)) begin
                    parse_error();
                end else if (r == 1) begin
                    if (len_acc == '0) begin
                        close_event(lst);
                    end else if (lst) begin
                        parse_error();
                    end else begin
                        skip_left   = len_acc;
                        tempo_acc   = '0;
                        parse_state = (parse_state == mtep_pkg::PH_MLEN) ?
                                      mtep_pkg::PH_MBODY : mtep_pkg::PH_XBODY;
                    end
                end
            end
            mtep_pkg::PH_MBODY, mtep_pkg::PH_XBODY: begin
                tempo_acc = {tempo_acc[mtep_pkg::TEMPO_W-9:0], b};
                skip_left = skip_left - mtep_pkg::LEN_W'(1);
                if (skip_left == '0) begin
                    if (parse_state == mtep_pkg::PH_MBODY &&
                        meta_code == mtep_pkg::META_TEMPO &&
                        len_acc == mtep_pkg::TEMPO_LEN)
                        note_event(mtep_pkg::KIND_TEMPO, '0, '0, '0, tempo_acc);
                    close_event(lst);
                end else if (lst) begin
                    parse_error();
                end
            end
            default: begin
                // Finished or failed: the byte is dropped until the next track start.
            end
        endcase
        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void dir_byte(input logic [7:0] d, input logic lst, input logic st);
        t_dir_row row;
        row       = '0;
        row.s     = '{data: d, last: lst, start: st};
        row.typed = 1'b0;
        dir_rows.push_back(row);
    endfunction

    function automatic void dir_byte_expect(input logic [7:0] d, input logic lst,
                                            input logic st, input logic [1:0] kind,
                                            input logic [mtep_pkg::TICK_W-1:0] tick);
        t_dir_row row;
        row       = '0;
        row.s     = '{data: d, last: lst, start: st};
        row.typed = 1'b1;
        row.kind  = kind;
        row.tick  = tick;
        dir_rows.push_back(row);
    endfunction

    function automatic void push_byte(input logic [7:0] d);
        t_stim s;
        s = '{data: d, last: 1'b0, start: 1'b0};
        track_bytes.push_back(s);
    endfunction

    // Encodes a length or delta, sometimes padded with leading zero groups.
    function automatic void push_length(input logic [mtep_pkg::LEN_W-1:0] value);
        int need;
        int n;
        need = 1;
        if (value >= 28'h80)     need = 2;
        if (value >= 28'h4000)   need = 3;
        if (value >= 28'h200000) need = 4;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 1;
        if (n < need) n = need;
        for (int i = n - 1; i >= 0; i--)
            push_byte({(i > 0), value[7*i +: 7]});
    endfunction

    function automatic logic [mtep_pkg::LEN_W-1:0] random_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return mtep_pkg::LEN_W'($urandom_range(1, 127));
            7:          return mtep_pkg::LEN_W'($urandom_range(128, 16383));
            8:          return mtep_pkg::LEN_W'($urandom_range(0, 32'h0FFFFFFF));
            default:    return MAX_VLQ;
        endcase
    endfunction

    // Four length bytes that all carry the continuation bit.
    function automatic void push_long_length();
        for (int i = 0; i < 4; i++)
            push_byte(CONT_BIT | 8'($urandom_range(0, 127)));
    endfunction

    // Builds one track body into track_bytes: mostly well-formed, sometimes damaged or noise.
    function automatic void build_track();
        int         pick;
        int         brk;
        int         n_events;
        int         len;
        int         pos;
        logic [7:0] st;
        logic [7:0] run_st;
        logic       have_running;
        logic       heavy;
        t_stim      s;
        track_bytes.delete();
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            n_events = $urandom_range(3, 20);
            for (int i = 0; i < n_events; i++) begin
                s.data  = 8'($urandom_range(0, 255));
                s.last  = ($urandom_range(0, 15) == 0);
                s.start = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0);
                track_bytes.push_back(s);
            end
            return;
        end
        heavy        = (pick == 1);
        brk          = ($urandom_range(0, 4) == 0) ? $urandom_range(BRK_TRUNCATE, BRK_LONG_LEN)
                                                   : BRK_NONE;
        n_events     = heavy ? 20 : $urandom_range(1, 10);
        have_running = 1'b0;
        run_st       = '0;
        for (int k = 0; k < n_events; k++) begin
            if (k == 0 && brk == BRK_LONG_DELTA) begin
                push_long_length();
            end else begin
                push_length(heavy ? MAX_VLQ : random_delta());
            end
            case ($urandom_range(0, 9))
                7: begin
                    push_byte(mtep_pkg::STATUS_META);
                    push_byte(mtep_pkg::META_TEMPO);
                    push_length(mtep_pkg::TEMPO_LEN);
                    for (int i = 0; i < 3; i++) push_byte(8'($urandom_range(0, 255)));
                end
                8, 9: begin
                    if ($urandom_range(0, 1) == 0) begin
                        push_byte(mtep_pkg::STATUS_META);
                        case ($urandom_range(0, 2))
                            0:       push_byte(mtep_pkg::META_TEMPO);
                            1:       push_byte(META_EOT);
                            default: push_byte(8'($urandom_range(0, 255)));
                        endcase
                    end else begin
                        push_byte(($urandom_range(0, 1) == 0) ? mtep_pkg::STATUS_SYSEX
                                                              : mtep_pkg::STATUS_ESC);
                    end
                    have_running = 1'b0;
                    len = $urandom_range(0, 5);
                    if (brk == BRK_LONG_LEN) begin
                        push_long_length();
                    end else begin
                        push_length(mtep_pkg::LEN_W'(len));
                    end
                    for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    // Channel message, under running status where one is in force.
                    if (have_running && $urandom_range(0, 1) == 0) begin
                        st = run_st;
                        push_byte(8'($urandom_range(0, 127)));
                    end else begin
                        st = 8'($urandom_range(8'h80, 8'hEF));
                        push_byte(st);
                        push_byte(8'($urandom_range(0, 255)));
                    end
                    if (channel_data_len(st) == 2) push_byte(8'($urandom_range(0, 255)));
                    have_running = 1'b1;
                    run_st       = st;
                end
            endcase
        end
        // Now and then the body ends straight after a delta.
        if ($urandom_range(0, 5) == 0) push_length(random_delta());
        track_bytes[track_bytes.size() - 1].last = 1'b1;
        track_bytes[0].start = ($urandom_range(0, 9) != 0);
        if (brk == BRK_TRUNCATE) begin
            pos = $urandom_range(0, track_bytes.size() - 1);
            track_bytes = track_bytes[0:pos];
            track_bytes[pos].last = 1'b1;
        end else if (brk == BRK_GARBLE) begin
            pos = $urandom_range(1, track_bytes.size() - 1);
            s   = '{data: 8'($urandom_range(0, 255)), last: 1'b0, start: 1'b0};
            if ($urandom_range(0, 1) == 0) track_bytes.insert(pos, s);
            else                           track_bytes[pos].data = s.data;
        end
    endfunction

    task automatic send_byte(input t_stim s, input logic typed, input logic [1:0] kind,
                             input logic [mtep_pkg::TICK_W-1:0] tick);
        mtep_pkg::t_result r;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= s.data;
        byte_ch.last_byte   <= s.last;
        byte_ch.track_start <= s.start;
        do @(posedge clk); while (!byte_ch.ready);
        sent_bytes++;
        decode_track_byte(s.data, s.last, s.start);
        if (typed) begin
            r             = '0;
            r.kind        = kind;
            r.event_tick  = tick;
            r.last_of_run = 1'b1;
            pending_events.push_back(r);
        end else begin
            foreach (byte_results[i]) pending_events.push_back(byte_results[i]);
        end
    endtask

    task automatic check_event(input mtep_pkg::t_result got);
        mtep_pkg::t_result want;
        if (pending_events.size() == 0) begin
            $error("unexpected result: kind %0d tick %0h", got.kind, got.event_tick);
            event_errors++;
            return;
        end
        want = pending_events.pop_front();
        if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            event_errors++;
        end
        if (got.event_tick != want.event_tick) begin
            $error("event_tick: expected %0h, got %0h", want.event_tick, got.event_tick);
            event_errors++;
        end
        if (got.status_byte != want.status_byte) begin
            $error("status_byte: expected %0h, got %0h", want.status_byte, got.status_byte);
            event_errors++;
        end
        if (got.first_data != want.first_data) begin
            $error("first_data: expected %0h, got %0h", want.first_data, got.first_data);
            event_errors++;
        end
        if (got.second_data != want.second_data) begin
            $error("second_data: expected %0h, got %0h", want.second_data, got.second_data);
            event_errors++;
        end
        if (got.tempo_value != want.tempo_value) begin
            $error("tempo_value: expected %0h, got %0h", want.tempo_value, got.tempo_value);
            event_errors++;
        end
        if (got.last_of_run != want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            event_errors++;
        end
    endtask

    // Result side: takes results and stalls in random bursts.
    initial begin : result_side
        int                stall_left;
        mtep_pkg::t_result got;
        stall_left = 0;
        evt_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && evt_ch.valid && evt_ch.ready) begin
                got.kind        = evt_ch.kind;
                got.event_tick  = evt_ch.event_tick;
                got.status_byte = evt_ch.status_byte;
                got.first_data  = evt_ch.first_data;
                got.second_data = evt_ch.second_data;
                got.tempo_value = evt_ch.tempo_value;
                got.last_of_run = evt_ch.last_of_run;
                check_event(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                evt_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= 1'b1;
            end
        end
    end

    // Byte side: reset, directed bytes, then random tracks.
    initial begin : byte_side
        rst_n               <= 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.last_byte   <= 1'b0;
        byte_ch.track_start <= 1'b0;
        clear_parser();

        // Program change, longest delta, two-byte message with a data byte above 7F.
        dir_byte(8'h00, 1'b0, 1'b1);
        dir_byte(8'hC5, 1'b0, 1'b0);
        dir_byte(8'h7F, 1'b0, 1'b0);
        dir_byte(8'hFF, 1'b0, 1'b0);
        dir_byte(8'hFF, 1'b0, 1'b0);
        dir_byte(8'hFF, 1'b0, 1'b0);
        dir_byte(8'h7F, 1'b0, 1'b0);
        dir_byte(8'h90, 1'b0, 1'b0);
        dir_byte(8'h3C, 1'b0, 1'b0);
        dir_byte(8'hFF, 1'b0, 1'b0);
        // Tempo meta event.
        dir_byte(8'h00, 1'b0, 1'b0);
        dir_byte(mtep_pkg::STATUS_META, 1'b0, 1'b0);
        dir_byte(mtep_pkg::META_TEMPO, 1'b0, 1'b0);
        dir_byte(8'h03, 1'b0, 1'b0);
        dir_byte(8'h07, 1'b0, 1'b0);
        dir_byte(8'hA1, 1'b0, 1'b0);
        dir_byte(8'h20, 1'b0, 1'b0);
        // The meta event cleared running status, so a data byte now is an error.
        dir_byte(8'h00, 1'b0, 1'b0);
        dir_byte_expect(8'h45, 1'b0, 1'b0, mtep_pkg::KIND_ERR, 32'h0FFFFFFF);
        // Undefined status.
        dir_byte(8'h00, 1'b0, 1'b1);
        dir_byte_expect(8'hF3, 1'b0, 1'b0, mtep_pkg::KIND_ERR, 32'h0);
        // Delta still continuing on its fourth byte.
        dir_byte(8'h80, 1'b0, 1'b1);
        dir_byte(8'h80, 1'b0, 1'b0);
        dir_byte(8'h80, 1'b0, 1'b0);
        dir_byte_expect(8'h80, 1'b0, 1'b0, mtep_pkg::KIND_ERR, 32'h0);
        // Channel pressure completing on the last byte: message, then end of track.
        dir_byte(8'h00, 1'b0, 1'b1);
        dir_byte(8'hD2, 1'b0, 1'b0);
        dir_byte(8'h40, 1'b1, 1'b0);
        // Body that is a single delta.
        dir_byte_expect(8'h7F, 1'b1, 1'b1, mtep_pkg::KIND_END, 32'h7F);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        gaps_on = 1'b1;
        foreach (dir_rows[i])
            send_byte(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].kind, dir_rows[i].tick);

        while (sent_bytes < TARGET_ITEMS) begin
            build_track();
            if (sent_bytes >= TARGET_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
            else                                         gaps_on = ($urandom_range(0, 4) != 0);
            foreach (track_bytes[i]) send_byte(track_bytes[i], 1'b0, mtep_pkg::KIND_CHAN, '0);
        end

        byte_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (event_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
